// ----- rtl/lcal_pkg.sv -----
// lcal_pkg: types, constants and helpers for the binary lifting common ancestor block
// used by every module under rtl but lcal_ram; no dependencies
`default_nettype none

package lcal_pkg;

	localparam int MAX_NODES = 1024;
	localparam int LEVELS    = 10;
	localparam int NODE_W    = 11;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int DEPTH_W   = $clog2(MAX_NODES);
	localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int ANC_DEPTH = LEVELS * MAX_NODES;
	localparam int ANC_AW    = $clog2(ANC_DEPTH);
	localparam int ST_N      = 23;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic ST_OK  = 1'b0;
	localparam logic ST_ERR = 1'b1;

	typedef struct packed {
		logic              op;
		logic [NODE_W-1:0] first_node;
		logic [NODE_W-1:0] second_node;
		logic [NODE_W-1:0] parent_node;
	} lcal_in_t;

	typedef struct packed {
		logic [NODE_W-1:0] ancestor;
		logic              status;
	} lcal_out_t;

	typedef enum logic [ST_N-1:0] {
		S_IDLE    = ST_N'(1) << 0,
		S_DECODE  = ST_N'(1) << 1,
		S_RB_ROOT = ST_N'(1) << 2,
		S_RB_A    = ST_N'(1) << 3,
		S_RB_AW   = ST_N'(1) << 4,
		S_RB_B    = ST_N'(1) << 5,
		S_RB_BW   = ST_N'(1) << 6,
		S_DP_INIT = ST_N'(1) << 7,
		S_DP_RD   = ST_N'(1) << 8,
		S_DP_W    = ST_N'(1) << 9,
		S_DP_WR   = ST_N'(1) << 10,
		S_Q_DU    = ST_N'(1) << 11,
		S_Q_DV    = ST_N'(1) << 12,
		S_Q_CHK   = ST_N'(1) << 13,
		S_Q_LIFT  = ST_N'(1) << 14,
		S_Q_LIFTW = ST_N'(1) << 15,
		S_Q_EQ    = ST_N'(1) << 16,
		S_Q_UP    = ST_N'(1) << 17,
		S_Q_UPA   = ST_N'(1) << 18,
		S_Q_UPB   = ST_N'(1) << 19,
		S_Q_FIN   = ST_N'(1) << 20,
		S_Q_FINW  = ST_N'(1) << 21,
		S_DONE    = ST_N'(1) << 22
	} state_t;

	typedef struct packed {
		state_t step;
	} lcal_cmd_t;

	typedef struct packed {
		logic op_query;
		logic bad_query;
		logic stale;
		logic skip_levels;
		logic j_last;
		logic lvl_last;
		logic lvl_zero;
		logic a_small;
		logic diff_bit;
		logic d_zero;
		logic uv_eq;
	} lcal_sts_t;

	function automatic logic [IDX_W-1:0] node_idx(input logic [NODE_W-1:0] node);
		return (node >= NODE_W'(MAX_NODES)) ? '0 : node[IDX_W-1:0];
	endfunction

	function automatic logic [ANC_AW-1:0] anc_addr(input logic [LVL_W-1:0] lvl,
			input logic [NODE_W-1:0] node);
		return ANC_AW'(lvl) * ANC_AW'(MAX_NODES) + ANC_AW'(node_idx(node));
	endfunction

endpackage

`default_nettype wire

// ----- rtl/lcal_ram.sv -----
// lcal_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module lcal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/lcal_ctrl.sv -----
// lcal_ctrl: sequencer for load, table rebuild and query walks
// depends on lcal_pkg
`default_nettype none

module lcal_ctrl
	import lcal_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  lcal_sts_t  sts,
	output lcal_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DECODE;
			end
			S_DECODE: begin
				priority if (!sts.op_query) state_d = S_IDLE;
				else if (sts.bad_query)     state_d = S_DONE;
				else if (sts.stale)         state_d = S_RB_ROOT;
				else                        state_d = S_Q_DU;
			end
			S_RB_ROOT: begin
				if (sts.lvl_last) state_d = sts.skip_levels ? S_DP_INIT : S_RB_A;
			end
			S_RB_A:  state_d = S_RB_AW;
			S_RB_AW: begin
				priority if (!sts.a_small)         state_d = S_RB_B;
				else if (sts.j_last && sts.lvl_last) state_d = S_DP_INIT;
				else                               state_d = S_RB_A;
			end
			S_RB_B:  state_d = S_RB_BW;
			S_RB_BW: state_d = (sts.j_last && sts.lvl_last) ? S_DP_INIT : S_RB_A;
			S_DP_INIT: state_d = S_DP_RD;
			S_DP_RD:   state_d = S_DP_W;
			S_DP_W:    state_d = sts.lvl_zero ? S_DP_WR : S_DP_RD;
			S_DP_WR:   state_d = sts.j_last ? S_Q_DU : S_DP_INIT;
			S_Q_DU:    state_d = S_Q_DV;
			S_Q_DV:    state_d = S_Q_CHK;
			S_Q_CHK:   state_d = (sts.d_zero || sts.uv_eq) ? S_DONE : S_Q_LIFT;
			S_Q_LIFT: begin
				priority if (sts.diff_bit) state_d = S_Q_LIFTW;
				else if (sts.lvl_last)     state_d = S_Q_EQ;
				else                       state_d = S_Q_LIFT;
			end
			S_Q_LIFTW: state_d = sts.lvl_last ? S_Q_EQ : S_Q_LIFT;
			S_Q_EQ:    state_d = sts.uv_eq ? S_DONE : S_Q_UP;
			S_Q_UP:    state_d = S_Q_UPA;
			S_Q_UPA:   state_d = S_Q_UPB;
			S_Q_UPB:   state_d = sts.lvl_zero ? S_Q_FIN : S_Q_UP;
			S_Q_FIN:   state_d = S_Q_FINW;
			S_Q_FINW:  state_d = S_DONE;
			S_DONE:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	assign cmd.step = state_q;
	assign busy     = (state_q != S_IDLE);
	assign done     = (state_q == S_DONE);

endmodule

`default_nettype wire

// ----- rtl/lcal_dp.sv -----
// lcal_dp: registers, ancestor and depth tables and walk arithmetic
// depends on lcal_pkg and lcal_ram
`default_nettype none

module lcal_dp
	import lcal_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  lcal_in_t          req,
	input  wire               cfg_we,
	input  wire  [NODE_W-1:0] cfg_wdata,
	input  lcal_cmd_t         cmd,
	output lcal_sts_t         sts,
	output lcal_out_t         rsp
);

	logic [NODE_W-1:0]  node_count_q;
	logic               stale_q;
	logic               op_q;
	logic [NODE_W-1:0]  u_q, v_q, p_q, j_q, a_q, cur_q, au_q, res_q;
	logic [DEPTH_W-1:0] du_q, diff_q, d_q;
	logic [LVL_W-1:0]   lvl_q;
	logic               vok_q;
	logic               err_q;

	logic [NODE_W-1:0]  n;
	logic [NODE_W-1:0]  anc_rd, filt, rd_node;
	logic [LVL_W-1:0]   rd_lvl, wr_lvl;
	logic [NODE_W-1:0]  wr_node, anc_wdata;
	logic               anc_we, dep_we;
	logic [DEPTH_W-1:0] dep_rd, dep_wdata;
	logic [NODE_W-1:0]  dep_rnode;
	logic               load_ok;
	state_t             step;

	assign step = cmd.step;
	assign n = (node_count_q > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : node_count_q;

	assign filt = (vok_q && anc_rd != '0 && anc_rd <= n) ? anc_rd : '0;
	assign load_ok = (u_q >= NODE_W'(2)) && (u_q <= n) && (p_q != '0) && (p_q <= n);

	// ancestor table read address
	always_comb begin
		rd_lvl  = lvl_q;
		rd_node = u_q;
		unique case (step)
			S_RB_A: begin
				rd_lvl  = lvl_q - LVL_W'(1);
				rd_node = j_q;
			end
			S_RB_B: begin
				rd_lvl  = lvl_q - LVL_W'(1);
				rd_node = a_q;
			end
			S_DP_RD: rd_node = cur_q;
			S_Q_UPA: rd_node = v_q;
			S_Q_FIN: rd_lvl  = '0;
			default: ;
		endcase
	end

	// ancestor table write
	always_comb begin
		anc_we    = 1'b0;
		wr_lvl    = lvl_q;
		wr_node   = j_q;
		anc_wdata = '0;
		unique case (step)
			S_DECODE: begin
				anc_we    = !op_q && load_ok;
				wr_lvl    = '0;
				wr_node   = u_q;
				anc_wdata = p_q;
			end
			S_RB_ROOT: begin
				anc_we  = 1'b1;
				wr_node = NODE_W'(1);
			end
			S_RB_AW: anc_we = (filt <= NODE_W'(1));
			S_RB_BW: begin
				anc_we    = 1'b1;
				anc_wdata = filt;
			end
			default: ;
		endcase
	end

	assign dep_we    = (step == S_DP_WR);
	assign dep_wdata = (cur_q == NODE_W'(1)) ? d_q : '0;
	assign dep_rnode = (step == S_Q_DV) ? v_q : u_q;

	lcal_ram #(.WIDTH(NODE_W), .DEPTH(ANC_DEPTH)) u_anc_ram (
		.clk   (clk),
		.we    (anc_we),
		.waddr (anc_addr(wr_lvl, wr_node)),
		.wdata (anc_wdata),
		.raddr (anc_addr(rd_lvl, rd_node)),
		.rdata (anc_rd)
	);

	lcal_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_NODES)) u_dep_ram (
		.clk   (clk),
		.we    (dep_we),
		.waddr (node_idx(j_q)),
		.wdata (dep_wdata),
		.raddr (node_idx((step == S_Q_DU) ? u_q : dep_rnode)),
		.rdata (dep_rd)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_W'(1);
			stale_q      <= 1'b1;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
				stale_q      <= 1'b1;
			end else if (step == S_DECODE && !op_q && load_ok) begin
				stale_q <= 1'b1;
			end else if (step == S_DP_WR && j_q == n) begin
				stale_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		vok_q <= (rd_node != '0) && (rd_node <= n);
		unique case (step)
			S_IDLE: begin
				op_q <= req.op;
				u_q  <= req.first_node;
				v_q  <= req.second_node;
				p_q  <= req.parent_node;
			end
			S_DECODE: begin
				err_q <= (u_q == '0) || (u_q > n) || (v_q == '0) || (v_q > n);
				res_q <= '0;
				lvl_q <= '0;
			end
			S_RB_ROOT: begin
				if (lvl_q == LVL_W'(LEVELS - 1)) begin
					lvl_q <= LVL_W'(1);
					j_q   <= sts.skip_levels ? NODE_W'(1) : NODE_W'(2);
				end else begin
					lvl_q <= lvl_q + LVL_W'(1);
				end
			end
			S_RB_AW, S_RB_BW: begin
				a_q <= filt;
				if (step == S_RB_BW || filt <= NODE_W'(1)) begin
					if (j_q == n) begin
						if (lvl_q == LVL_W'(LEVELS - 1)) begin
							j_q <= NODE_W'(1);
						end else begin
							j_q   <= NODE_W'(2);
							lvl_q <= lvl_q + LVL_W'(1);
						end
					end else begin
						j_q <= j_q + NODE_W'(1);
					end
				end
			end
			S_DP_INIT: begin
				cur_q <= j_q;
				d_q   <= '0;
				lvl_q <= LVL_W'(LEVELS - 1);
			end
			S_DP_W: begin
				if (filt != '0) begin
					cur_q <= filt;
					d_q   <= d_q + (DEPTH_W'(1) << lvl_q);
				end
				if (lvl_q != '0) lvl_q <= lvl_q - LVL_W'(1);
			end
			S_DP_WR: begin
				if (j_q != n) j_q <= j_q + NODE_W'(1);
			end
			S_Q_DV: du_q <= dep_rd;
			S_Q_CHK: begin
				err_q <= ST_OK;
				lvl_q <= '0;
				if (du_q == '0 || dep_rd == '0) begin
					res_q <= NODE_W'(1);
				end else begin
					res_q <= u_q;
				end
				if (du_q < dep_rd) begin
					u_q    <= v_q;
					v_q    <= u_q;
					diff_q <= dep_rd - du_q;
				end else begin
					diff_q <= du_q - dep_rd;
				end
			end
			S_Q_LIFT: begin
				if (!diff_q[lvl_q] && lvl_q != LVL_W'(LEVELS - 1)) lvl_q <= lvl_q + LVL_W'(1);
			end
			S_Q_LIFTW: begin
				u_q <= filt;
				if (lvl_q != LVL_W'(LEVELS - 1)) lvl_q <= lvl_q + LVL_W'(1);
			end
			S_Q_EQ: begin
				res_q <= u_q;
				lvl_q <= LVL_W'(LEVELS - 1);
			end
			S_Q_UPA: au_q <= filt;
			S_Q_UPB: begin
				if (au_q != filt) begin
					u_q <= au_q;
					v_q <= filt;
				end
				if (lvl_q != '0) lvl_q <= lvl_q - LVL_W'(1);
			end
			S_Q_FINW: res_q <= filt;
			default: ;
		endcase
	end

	assign sts.op_query    = (op_q == OP_QUERY);
	assign sts.bad_query   = (u_q == '0) || (u_q > n) || (v_q == '0) || (v_q > n);
	assign sts.stale       = stale_q;
	assign sts.skip_levels = (n < NODE_W'(2)) || (LEVELS == 1);
	assign sts.j_last      = (j_q == n);
	assign sts.lvl_last    = (lvl_q == LVL_W'(LEVELS - 1));
	assign sts.lvl_zero    = (lvl_q == '0);
	assign sts.a_small     = (filt <= NODE_W'(1));
	assign sts.diff_bit    = diff_q[lvl_q];
	assign sts.d_zero      = (du_q == '0) || (dep_rd == '0);
	assign sts.uv_eq       = (u_q == v_q);

	assign rsp.ancestor = err_q ? '0 : res_q;
	assign rsp.status   = err_q;

endmodule

`default_nettype wire

// ----- rtl/lowest_common_ancestor_lifting.sv -----
// lowest_common_ancestor_lifting: top level of the binary lifting common ancestor block
// depends on lcal_pkg, lcal_ctrl, lcal_dp (and lcal_ram below it)
//
// Usage: present a beat on req with start high; it is taken when busy is low.
// A load beat (op 0) writes one parent entry when its nodes are in range and
// gives no result. A query beat (op 1) gives one result on rsp, marked by
// done for exactly one cycle; the receiver cannot stall it.
// An out-of-range query answers with status 1, ancestor 0.
// A query on fresh tables is paced by the ancestor table lookups of the
// lifting walks, each through the registered ram read.
// The first in-range query after a valid load or a node_count write first
// rebuilds the tables: the root row, then the lifting rows level by level
// and node by node, then the depths node by node, with the ancestor ram
// read and written through its single read port and single write port.
// cfg_we/cfg_wdata write node_count; write it only while busy is low.
// Reset sets node_count to 1 and marks the tables for rebuild; the tables
// themselves are not cleared.
`default_nettype none

module lowest_common_ancestor_lifting
	import lcal_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  lcal_in_t          req,
	output logic              done,
	output lcal_out_t         rsp,
	input  wire               cfg_we,
	input  wire  [NODE_W-1:0] cfg_wdata
);

	lcal_cmd_t cmd;
	lcal_sts_t sts;

	lcal_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	lcal_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// tb_top: self-checking testbench for lowest_common_ancestor_lifting
// depends on rtl/lcal_pkg.sv and rtl/lowest_common_ancestor_lifting.sv
// directed table then random load/query beats, checked against a binary lifting predictor
`timescale 1ns / 100ps

module tb_top
	import lcal_pkg::*;
();

	typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [10:0] cfg_val;
		lcal_in_t    beat;
		logic        typed;
		lcal_out_t   answer;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	lcal_in_t    req;
	logic        done;
	lcal_out_t   rsp;
	logic        cfg_we;
	logic [10:0] cfg_wdata;

	lcal_out_t   answers_due[$];
	int unsigned err_cnt;
	int unsigned idle_pct;

	int unsigned lift[LEVELS][MAX_NODES+1];
	int unsigned node_depth[MAX_NODES+1];
	bit          parent_set[MAX_NODES+1];
	bit          lift_stale;
	int unsigned node_total;

	lowest_common_ancestor_lifting u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200000000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int unsigned nodes_used();
		return (node_total > MAX_NODES) ? MAX_NODES : node_total;
	endfunction

	function automatic int unsigned up(int unsigned l, int unsigned v, int unsigned n);
		int unsigned a;
		if (l >= LEVELS || v == 0 || v > n)
			return 0;
		a = lift[l][v];
		return (a > n) ? 0 : a;
	endfunction

	function automatic void rebuild_lift();
		int unsigned n, a, cur, d;
		n = nodes_used();
		for (int l = 0; l < LEVELS; l++)
			lift[l][1] = 0;
		for (int l = 1; l < LEVELS; l++) begin
			for (int j = 2; j <= n; j++) begin
				a = up(l - 1, j, n);
				lift[l][j] = (a <= 1) ? 0 : up(l - 1, a, n);
			end
		end
		for (int j = 1; j <= n; j++) begin
			cur = j;
			d = 0;
			for (int l = LEVELS - 1; l >= 0; l--) begin
				a = up(l, cur, n);
				if (a != 0) begin
					cur = a;
					d += 1 << l;
				end
			end
			node_depth[j] = (cur == 1) ? d : 0;
		end
		lift_stale = 0;
	endfunction

	function automatic int unsigned common_ancestor(int unsigned u, int unsigned v);
		int unsigned n, du, dv, t, diff, au, av;
		n = nodes_used();
		du = node_depth[u];
		dv = node_depth[v];
		if (du == 0 || dv == 0)
			return 1;
		if (u == v)
			return u;
		if (du < dv) begin
			t = u; u = v; v = t;
			t = du; du = dv; dv = t;
		end
		diff = du - dv;
		for (int l = 0; l < LEVELS; l++)
			if ((diff >> l) & 1)
				u = up(l, u, n);
		if (u == v)
			return u;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			au = up(l, u, n);
			av = up(l, v, n);
			if (au != av) begin
				u = au;
				v = av;
			end
		end
		return up(0, u, n);
	endfunction

	// applies one accepted beat, returns 1 with the answer when a query
	function automatic bit apply_beat(lcal_in_t b, output lcal_out_t ans);
		int unsigned n, a, c, p;
		n = nodes_used();
		a = b.first_node;
		c = b.second_node;
		p = b.parent_node;
		ans = '0;
		if (b.op == OP_LOAD) begin
			if (a >= 2 && a <= n && p >= 1 && p <= n) begin
				lift[0][a] = p;
				parent_set[a] = 1;
				lift_stale = 1;
			end
			return 0;
		end
		if (a == 0 || a > n || c == 0 || c > n) begin
			ans.status = ST_ERR;
			return 1;
		end
		if (lift_stale)
			rebuild_lift();
		ans.ancestor = 11'(common_ancestor(a, c));
		ans.status = ST_OK;
		return 1;
	endfunction

	// called just after a rising edge; returns just after the accepting edge
	task automatic send_beat(lcal_in_t b, bit typed, lcal_out_t typed_ans);
		bit acc;
		lcal_out_t ans;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= b;
		do begin
			#1 acc = !busy;
			@(posedge clk);
		end while (!acc);
		if (apply_beat(b, ans))
			answers_due.insert(answers_due.size(), typed ? typed_ans : ans);
	endtask

	task automatic write_node_count(logic [10:0] v);
		start <= 1'b0;
		wait (answers_due.size() == 0);
		@(posedge clk);
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		node_total = v;
		lift_stale = 1;
	endtask

	function automatic lcal_in_t mk(logic op, int a, int b, int p);
		lcal_in_t r;
		r.op = op;
		r.first_node = 11'(a);
		r.second_node = 11'(b);
		r.parent_node = 11'(p);
		return r;
	endfunction

	task automatic fill_parents();
		int unsigned n;
		n = nodes_used();
		for (int j = 2; j <= n; j++)
			if (!parent_set[j])
				send_beat(mk(OP_LOAD, j, $urandom, $urandom_range(j - 1, 1)), 0, '0);
	endtask

	task automatic random_phase(logic [10:0] ncfg, int unsigned beats);
		int unsigned n, k, burst;
		bit big;
		lcal_in_t b;
		write_node_count(ncfg);
		n = nodes_used();
		big = (n > 64);
		fill_parents();
		k = 0;
		while (k < beats) begin
			burst = $urandom_range(10, 3);
			if (!big && n > 1 && $urandom_range(99) < 25) begin
				// a burst of parent rewrites, some making cycles
				for (int i = 0; i < burst / 2 + 1; i++) begin
					b = mk(OP_LOAD, $urandom_range(n, 2), $urandom,
						($urandom_range(3) == 0) ? $urandom_range(n, 1) : 1);
					if ($urandom_range(1))
						b.parent_node = 11'($urandom_range(b.first_node - 1, 1));
					send_beat(b, 0, '0);
					k++;
				end
			end else begin
				for (int i = 0; i < burst; i++) begin
					case ($urandom_range(9))
						0: b = mk(OP_QUERY, $urandom, $urandom, $urandom);
						1: b = mk(OP_LOAD, $urandom, $urandom, $urandom);
						2: b = mk(OP_QUERY, $urandom_range(n, 1), $urandom_range(n, 1), $urandom);
						default: begin
							b = mk(OP_QUERY, $urandom_range(n, 1), $urandom_range(n, 1),
								$urandom);
							if ($urandom_range(3) == 0)
								b.second_node = b.first_node;
						end
					endcase
					if (b.op == OP_QUERY)
						k++;
					send_beat(b, 0, '0);
				end
			end
		end
	endtask

	always @(negedge clk) begin
		lcal_out_t want;
		if (arst_n && done) begin
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected result, got anc %0d st %0d", $time,
					rsp.ancestor, rsp.status);
				err_cnt++;
			end else begin
				want = answers_due.pop_front();
				if (rsp.ancestor !== want.ancestor || rsp.status !== want.status) begin
					$display("%0t: mismatch, expected anc %0d st %0d, got anc %0d st %0d",
						$time, want.ancestor, want.status, rsp.ancestor, rsp.status);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		logic [10:0] sizes[9];
		int unsigned wait_cnt;

		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		err_cnt = 0;
		idle_pct = 0;
		node_total = 1;
		lift_stale = 1;
		for (int l = 0; l < LEVELS; l++)
			for (int j = 0; j <= MAX_NODES; j++)
				lift[l][j] = 0;
		for (int j = 0; j <= MAX_NODES; j++) begin
			node_depth[j] = 0;
			parent_set[j] = 0;
		end

		// kind, cfg, beat, typed, answer {ancestor, status}
		rows = '{
			'{ROW_BEAT, 0, mk(OP_QUERY, 1, 1, 0), 1, '{11'd1, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_QUERY, 2, 1, 0), 1, '{11'd0, ST_ERR}},
			'{ROW_BEAT, 0, mk(OP_QUERY, 0, 1, 2047), 1, '{11'd0, ST_ERR}},
			'{ROW_BEAT, 0, mk(OP_QUERY, 1, 2047, 0), 1, '{11'd0, ST_ERR}},
			'{ROW_BEAT, 0, mk(OP_LOAD, 1, 2047, 1), 0, '{11'd0, ST_OK}},
			'{ROW_CFG, 8, mk(OP_LOAD, 0, 0, 0), 0, '{11'd0, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_LOAD, 2, 0, 1), 0, '{11'd0, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_LOAD, 3, 0, 1), 0, '{11'd0, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_LOAD, 4, 0, 2), 0, '{11'd0, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_LOAD, 5, 0, 2), 0, '{11'd0, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_LOAD, 6, 0, 4), 0, '{11'd0, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_LOAD, 7, 0, 6), 0, '{11'd0, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_LOAD, 8, 0, 9), 0, '{11'd0, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_LOAD, 8, 0, 7), 0, '{11'd0, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_QUERY, 5, 7, 0), 0, '{11'd0, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_QUERY, 7, 7, 0), 1, '{11'd7, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_QUERY, 1, 6, 0), 1, '{11'd1, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_QUERY, 9, 1, 0), 1, '{11'd0, ST_ERR}},
			'{ROW_BEAT, 0, mk(OP_QUERY, 8, 3, 0), 0, '{11'd0, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_QUERY, 8, 5, 0), 0, '{11'd0, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_LOAD, 8, 0, 8), 0, '{11'd0, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_QUERY, 8, 3, 0), 1, '{11'd1, ST_OK}},
			'{ROW_BEAT, 0, mk(OP_QUERY, 6, 6, 0), 1, '{11'd6, ST_OK}}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			r = rows[i];
			if (r.kind == ROW_CFG)
				write_node_count(r.cfg_val);
			else
				send_beat(r.beat, r.typed, r.answer);
		end

		sizes = '{11'd3, 11'd16, 11'd2047, 11'd1, 11'd40, 11'd9, 11'd1024, 11'd12, 11'd2};
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 63;
				2: idle_pct = 12;
				default: idle_pct = 63;
			endcase
			random_phase(sizes[ph % 9], (sizes[ph % 9] > 64) ? 40 : 70);
		end

		start <= 1'b0;
		wait_cnt = 0;
		while (answers_due.size() != 0 && wait_cnt < 200000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (20) @(posedge clk);
		if (err_cnt == 0 && answers_due.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/lcal_pkg.sv
rtl/lcal_ram.sv
rtl/lcal_ctrl.sv
rtl/lcal_dp.sv
rtl/lowest_common_ancestor_lifting.sv
sim/tb_top.sv
